// ===== hw/rtl/hsvc_pkg.sv =====
`timescale 1ns / 1ps

package hsvc_pkg;

    localparam int PIXEL_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int CLASS_W     = 3;
    localparam int SNUM_W      = 16;
    localparam int HNUM_W      = 14;
    localparam int DIV_STAGES  = 8;
    localparam int MID_DEPTH_D = 2;
    localparam int OUT_DEPTH_D = 2;

    localparam logic [CLASS_W-1:0] CLS_BLACK  = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_RED    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_GREEN  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_BLUE   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_YELLOW = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_ORANGE = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_NONE   = 3'd6;

    localparam logic [CHAN_W-1:0] BASE_RED   = 8'd0;
    localparam logic [CHAN_W-1:0] BASE_GREEN = 8'd85;
    localparam logic [CHAN_W-1:0] BASE_BLUE  = 8'd171;

    typedef struct packed {
        logic [SNUM_W-1:0] s_num;
        logic [CHAN_W-1:0] mx;
        logic [HNUM_W-1:0] h_num;
        logic [CHAN_W-1:0] delta;
        logic [CHAN_W-1:0] base;
        logic              neg;
        logic              black;
    } t_prep;

    typedef struct packed {
        logic [CHAN_W-1:0]  hue;
        logic [CHAN_W-1:0]  saturation;
        logic [CHAN_W-1:0]  brightness;
        logic [CLASS_W-1:0] color_class;
    } t_res;

endpackage

// ===== hw/rtl/rgb565_hsv_color_classifier.sv =====
`timescale 1ns / 1ps

// RGB565 pixel to 8-bit HSV converter and color classifier.
// The input side is a queue: a pixel word on i_pixel is taken at a rising
// edge where push is high and full is low.
// The result side is a queue too: while empty is low the oldest result word
// is on o_hue, o_saturation, o_brightness and o_color_class, and it is taken
// at a rising edge where pop is high and empty is low.
// One pixel word is accepted per cycle while full is low, and one result
// word leaves per cycle while pop is high and empty is low. A pixel first
// lands in a small input queue. The back end pulls it into an eight-stage
// pipelined divider, one quotient bit per stage, which computes saturation
// and hue together; the result is then classified and written into the
// output queue.
// When the receiver stops popping, the output queue fills, the divider
// pipeline holds, and then the input queue fills and raises full. Nothing is
// lost and the input keeps flowing until both queues are full.
// A synchronous reset empties both queues and clears all pipeline valid bits.

module rgb565_hsv_color_classifier #(
    parameter int MID_DEPTH = hsvc_pkg::MID_DEPTH_D,
    parameter int OUT_DEPTH = hsvc_pkg::OUT_DEPTH_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  logic [hsvc_pkg::PIXEL_W-1:0]  i_pixel,
    output logic                          full,
    output logic                          empty,
    input  logic                          pop,
    output logic [hsvc_pkg::CHAN_W-1:0]   o_hue,
    output logic [hsvc_pkg::CHAN_W-1:0]   o_saturation,
    output logic [hsvc_pkg::CHAN_W-1:0]   o_brightness,
    output logic [hsvc_pkg::CLASS_W-1:0]  o_color_class
);

    import hsvc_pkg::*;

    t_prep front_prep, mid_prep;
    t_res  back_res, out_res;
    logic  mid_empty, mid_pop, res_full, res_push;

    hsvc_front u_front (
        .i_pixel (i_pixel),
        .o_prep  (front_prep)
    );

    hsvc_fifo #(
        .W     ($bits(t_prep)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_prep),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_rdata (mid_prep),
        .o_empty (mid_empty)
    );

    hsvc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_prep       (mid_prep),
        .i_prep_valid (!mid_empty),
        .o_prep_pop   (mid_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (back_res)
    );

    hsvc_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (out_res),
        .o_empty (empty)
    );

    assign o_hue         = out_res.hue;
    assign o_saturation  = out_res.saturation;
    assign o_brightness  = out_res.brightness;
    assign o_color_class = out_res.color_class;

`ifndef SYNTHESIS
    a_gray_no_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_saturation == '0) |-> (o_hue == '0))
        else $error("hue is nonzero for a gray result word");

    a_dark_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_brightness == '0) |-> (o_saturation == '0))
        else $error("saturation is nonzero for a zero brightness word");

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_color_class != CLS_ORANGE && o_color_class <= CLS_NONE))
        else $error("illegal color class in result word");

    a_red_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_color_class == CLS_RED) |->
        (o_hue <= 8'd20 || o_hue >= 8'd220))
        else $error("red class with hue outside the red window");
`endif

endmodule

// ===== hw/rtl/hsvc_fifo.sv =====
`timescale 1ns / 1ps

module hsvc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== hw/rtl/hsvc_front.sv =====
`timescale 1ns / 1ps

module hsvc_front (
    input  logic [hsvc_pkg::PIXEL_W-1:0] i_pixel,
    output hsvc_pkg::t_prep              o_prep
);

    import hsvc_pkg::*;

    logic [4:0]        r5, b5, hg;
    logic [5:0]        g6;
    logic [CHAN_W-1:0] r, g, b, mx, mn, mag;
    logic signed [8:0] diff;
    logic signed [5:0] d_br, d_hb, d_rh;
    logic              near_br, near_hb, near_rh;

    always_comb begin
        r5 = i_pixel[15:11];
        g6 = i_pixel[10:5];
        b5 = i_pixel[4:0];
        hg = g6[5:1];
        r  = {r5, r5[4:2]};
        g  = {g6, g6[5:4]};
        b  = {b5, b5[4:2]};

        mx = r;
        if (g > mx) begin
            mx = g;
        end
        if (b > mx) begin
            mx = b;
        end
        mn = r;
        if (g < mn) begin
            mn = g;
        end
        if (b < mn) begin
            mn = b;
        end

        priority if (mx == r) begin
            o_prep.base = BASE_RED;
            diff = $signed({1'b0, g}) - $signed({1'b0, b});
        end else if (mx == g) begin
            o_prep.base = BASE_GREEN;
            diff = $signed({1'b0, b}) - $signed({1'b0, r});
        end else begin
            o_prep.base = BASE_BLUE;
            diff = $signed({1'b0, r}) - $signed({1'b0, g});
        end
        mag = diff[8] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];

        o_prep.mx    = mx;
        o_prep.delta = mx - mn;
        o_prep.s_num = SNUM_W'(mx - mn) * SNUM_W'(255);
        o_prep.h_num = HNUM_W'(mag) * HNUM_W'(43);
        o_prep.neg   = diff[8];

        d_br = $signed({1'b0, b5}) - $signed({1'b0, r5});
        d_hb = $signed({1'b0, hg}) - $signed({1'b0, b5});
        d_rh = $signed({1'b0, r5}) - $signed({1'b0, hg});
        near_br = (d_br >= -6'sd4) && (d_br <= 6'sd4);
        near_hb = (d_hb >= -6'sd7) && (d_hb <= 6'sd7);
        near_rh = (d_rh >= -6'sd7) && (d_rh <= 6'sd7);
        o_prep.black = near_br && near_hb && near_rh &&
                       (r5 < 5'd24) && (g6 < 6'd48) && (b5 < 5'd24);
    end

endmodule

// ===== hw/rtl/hsvc_back.sv =====
`timescale 1ns / 1ps

module hsvc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hsvc_pkg::t_prep i_prep,
    input  logic            i_prep_valid,
    output logic            o_prep_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output hsvc_pkg::t_res  o_res
);

    import hsvc_pkg::*;

    typedef struct packed {
        logic [SNUM_W-1:0] s_rem;
        logic [CHAN_W-1:0] s_dvs;
        logic [CHAN_W-1:0] s_q;
        logic [SNUM_W-1:0] h_rem;
        logic [CHAN_W-1:0] h_dvs;
        logic [CHAN_W-1:0] h_q;
        logic [CHAN_W-1:0] base;
        logic              neg;
        logic              black;
    } t_div;

    t_div  r_stg [0:DIV_STAGES];
    t_div  n_stg [1:DIV_STAGES];
    logic  r_vld [0:DIV_STAGES];
    logic  en;
    t_div  fin;
    logic [CHAN_W-1:0] h, s, v;
    logic [CLASS_W-1:0] cls;

    assign en         = !i_res_full;
    assign o_prep_pop = en && i_prep_valid;

    always_comb begin
        logic [SNUM_W-1:0] s_sh, h_sh;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            n_stg[k] = r_stg[k-1];
            s_sh = SNUM_W'(r_stg[k-1].s_dvs) << (DIV_STAGES - k);
            h_sh = SNUM_W'(r_stg[k-1].h_dvs) << (DIV_STAGES - k);
            if (r_stg[k-1].s_rem >= s_sh) begin
                n_stg[k].s_rem = r_stg[k-1].s_rem - s_sh;
                n_stg[k].s_q[DIV_STAGES-k] = 1'b1;
            end
            if (r_stg[k-1].h_rem >= h_sh) begin
                n_stg[k].h_rem = r_stg[k-1].h_rem - h_sh;
                n_stg[k].h_q[DIV_STAGES-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_prep_valid;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_stg[0].s_rem <= i_prep.s_num;
            r_stg[0].s_dvs <= i_prep.mx;
            r_stg[0].s_q   <= '0;
            r_stg[0].h_rem <= SNUM_W'(i_prep.h_num);
            r_stg[0].h_dvs <= i_prep.delta;
            r_stg[0].h_q   <= '0;
            r_stg[0].base  <= i_prep.base;
            r_stg[0].neg   <= i_prep.neg;
            r_stg[0].black <= i_prep.black;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_comb begin
        fin = r_stg[DIV_STAGES];
        v   = fin.s_dvs;
        s   = (fin.s_dvs == '0) ? '0 : fin.s_q;
        if (fin.h_dvs == '0) begin
            h = '0;
        end else if (fin.neg) begin
            h = fin.base - fin.h_q;
        end else begin
            h = fin.base + fin.h_q;
        end

        priority if (fin.black) begin
            cls = CLS_BLACK;
        end else if (h <= 8'd20 || h >= 8'd220) begin
            cls = CLS_RED;
        end else if (h >= 8'd55 && h <= 8'd120 && s >= 8'd25 && v >= 8'd25) begin
            cls = CLS_GREEN;
        end else if (h >= 8'd120 && h <= 8'd165 && s >= 8'd35 &&
                     v >= 8'd30 && v <= 8'd250) begin
            cls = CLS_BLUE;
        end else if (h >= 8'd25 && h <= 8'd55 && s >= 8'd50 &&
                     v >= 8'd30 && v <= 8'd250) begin
            cls = CLS_YELLOW;
        end else if ((h >= 8'd230 || h <= 8'd15) && h <= 8'd180) begin
            cls = CLS_ORANGE;
        end else begin
            cls = CLS_NONE;
        end

        o_res.hue         = h;
        o_res.saturation  = s;
        o_res.brightness  = v;
        o_res.color_class = cls;
    end

    assign o_res_push = en && r_vld[DIV_STAGES];

endmodule
